@@ rtl/core/lpsr_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the led panel scan remap block
// no dependencies; imported by lpsr_addr_map, led_panel_scan_remap_unit and tb_top
package lpsr_pkg;

	localparam int IDX_W      = 12;
	localparam int VALUE_W    = 8;
	localparam int BUF_ADDR_W = 16;
	localparam int LAYOUT_W   = 3;
	localparam int BLOCK_W    = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// wide enough for the largest address any layout can reach
	localparam int ADDR_W = 32;

	// panel layout codes
	localparam logic [LAYOUT_W-1:0] LAYOUT_P15     = 3'd0;
	localparam logic [LAYOUT_W-1:0] LAYOUT_P5      = 3'd1;
	localparam logic [LAYOUT_W-1:0] LAYOUT_P6      = 3'd2;
	localparam logic [LAYOUT_W-1:0] LAYOUT_P10     = 3'd3;
	localparam logic [LAYOUT_W-1:0] LAYOUT_P5V     = 3'd4;
	localparam logic [LAYOUT_W-1:0] LAYOUT_DEFAULT = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_LAYOUT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_PIXELS = 4'd1;

	localparam logic [LAYOUT_W-1:0] PANEL_LAYOUT_RESET = LAYOUT_P15;
	localparam logic [BLOCK_W-1:0]  BLOCK_PIXELS_RESET = 16'd64;

	typedef struct packed {
		logic [LAYOUT_W-1:0] panel_layout;
		logic [BLOCK_W-1:0]  block_pixels;
	} lpsr_cfg_t;

endpackage

@@ rtl/core/lpsr_addr_map.sv @@
`timescale 1ns / 1ps
// combinational scan buffer address for one pixel, all six panel layouts
// depends on lpsr_pkg for the layout codes and the configuration struct
module lpsr_addr_map #(
	parameter int ROW_W           = 5,
	parameter int COL_W           = 7,
	parameter int GROUP_WORDS     = 16,
	parameter int MODULES_ACROSS  = 4,
	parameter int MODULE_WIDTH    = 32,
	parameter int SCAN_LINE_WORDS = 256
) (
	input  logic [ROW_W-1:0]             row,
	input  logic [COL_W-1:0]             col,
	input  lpsr_pkg::lpsr_cfg_t          cfg,
	output logic [lpsr_pkg::ADDR_W-1:0]  addr
);
	import lpsr_pkg::*;

	localparam logic [ADDR_W-1:0] GW          = ADDR_W'(GROUP_WORDS);
	localparam logic [ADDR_W-1:0] ROW4_GROUPS = ADDR_W'(MODULES_ACROSS * 4);
	localparam logic [ADDR_W-1:0] MW          = ADDR_W'(MODULE_WIDTH);
	localparam logic [ADDR_W-1:0] SLW         = ADDR_W'(SCAN_LINE_WORDS);
	localparam logic [ADDR_W-1:0] LINE_GROUPS = ADDR_W'(SCAN_LINE_WORDS / GROUP_WORDS);
	// column / MODULE_WIDTH by reciprocal, exact for 8-bit columns
	localparam int                MOD_SHIFT   = 16;
	localparam logic [ADDR_W-1:0] MOD_RECIP   =
		ADDR_W'(((1 << MOD_SHIFT) + MODULE_WIDTH - 1) / MODULE_WIDTH);

	logic [ADDR_W-1:0] rx, cx, bpx, c3;
	logic [ADDR_W-1:0] g15, b15, q15, a15;
	logic [ADDR_W-1:0] gh, b5, a5;
	logic [ADDR_W-1:0] mod6, b6, a6;
	logic [ADDR_W-1:0] g10, b10, a10;
	logic [ADDR_W-1:0] line5v, a5v;
	logic [ADDR_W-1:0] gd, bd, ad;

	assign rx  = ADDR_W'(row);
	assign cx  = ADDR_W'(col);
	assign bpx = ADDR_W'(cfg.block_pixels);
	assign c3  = ADDR_W'(cx[2:0]);

	// p15: four-row groups, upper pair reversed within the group
	assign g15 = (cx >> 2) + (rx >> 2) * ROW4_GROUPS;
	assign b15 = g15 * GW;
	assign q15 = ADDR_W'(cx[1:0]);
	always_comb begin
		case (rx[1:0])
			2'd0:    a15 = b15 + ((ADDR_W'(3) - q15) << 1);
			2'd1:    a15 = b15 + ((ADDR_W'(3) - q15) << 1) + ADDR_W'(1);
			2'd2:    a15 = b15 + (q15 << 1) + ADDR_W'(9);
			default: a15 = b15 + (q15 << 1) + ADDR_W'(8);
		endcase
	end

	// scan group shared by p5 and p6: eight lines per sixteen rows
	assign gh = ((rx >> 4) << 3) + ADDR_W'(rx[2:0]);

	assign b5 = gh * GW + (cx << 1);
	assign a5 = rx[3] ? b5 : b5 + ADDR_W'(1);

	assign mod6 = (cx * MOD_RECIP) >> MOD_SHIFT;
	assign b6   = cx + gh * GW;
	assign a6   = rx[3] ? b6 + mod6 * MW : b6 + (mod6 + ADDR_W'(1)) * MW;

	// p10: lower half of each eight-row band runs reversed
	assign g10 = (ADDR_W'(rx[1:0]) + ((rx >> 3) << 2)) * LINE_GROUPS + (cx >> 3);
	assign b10 = g10 * GW;
	assign a10 = rx[2] ? b10 + ADDR_W'(15) - c3 : b10 + c3;

	// p5 vertical: columns become scan lines, reversed in blocks of eight
	assign line5v = (((cx >> 4) + ADDR_W'(1)) << 3) - ADDR_W'(1) - c3;
	assign a5v    = line5v * SLW + (rx << 1) + ADDR_W'(cx[3]);

	assign gd = (cx >> 5) * bpx
		+ (rx[3] ? (bpx >> 1) : '0)
		+ ((ADDR_W'(rx[1:0]) << 2) + ((rx >> 4) << 4))
		+ ADDR_W'(cx[4:3]);
	assign bd = gd * GW + c3;
	assign ad = rx[2] ? bd + ADDR_W'(8) : bd;

	always_comb begin
		case (cfg.panel_layout)
			LAYOUT_P15: addr = a15;
			LAYOUT_P5:  addr = a5;
			LAYOUT_P6:  addr = a6;
			LAYOUT_P10: addr = a10;
			LAYOUT_P5V: addr = a5v;
			default:    addr = ad;
		endcase
	end

endmodule

@@ rtl/core/led_panel_scan_remap_unit.sv @@
`timescale 1ns / 1ps
// led panel scan remap: raster pixel index to scan buffer address
// depends on lpsr_pkg and lpsr_addr_map
//
//   port group   direction  beat contents
//   cfg_*        in         cfg_index, cfg_data (register write)
//   pixel_*      in         pixel_index, pixel_value
//   buffer_*     out        buffer_address, buffer_value, address_overflow
//
// one pixel per clock sustained while results are accepted; the result leaves from the address reg
// stages: input reg, reciprocal multiply for row, row/column split, address reg
// the whole pipe holds while a result sits unaccepted; pixel_ready drops then
// reset clears all stage valids and sets the layout and block size registers
// cfg_ready is always high; a write beyond the register list is ignored
module led_panel_scan_remap_unit #(
	parameter int SCREEN_WIDTH    = 128,
	parameter int GROUP_WORDS     = 16,
	parameter int MODULES_ACROSS  = 4,
	parameter int MODULE_WIDTH    = 32,
	parameter int SCAN_LINE_WORDS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lpsr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpsr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               pixel_valid,
	output logic                               pixel_ready,
	input  logic [lpsr_pkg::IDX_W-1:0]         pixel_index,
	input  logic [lpsr_pkg::VALUE_W-1:0]       pixel_value,
	output logic                               buffer_valid,
	input  logic                               buffer_ready,
	output logic [lpsr_pkg::BUF_ADDR_W-1:0]    buffer_address,
	output logic [lpsr_pkg::VALUE_W-1:0]       buffer_value,
	output logic                               address_overflow
);
	import lpsr_pkg::*;

	localparam int IDX_MAX     = (1 << IDX_W) - 1;
	localparam int ROW_W       = $clog2(IDX_MAX / SCREEN_WIDTH + 1);
	localparam int COL_W       = $clog2(SCREEN_WIDTH);
	// index / SCREEN_WIDTH = (index * RECIP) >> RECIP_SHIFT, exact for 12-bit index
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP       = ((1 << RECIP_SHIFT) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int PROD_W      = IDX_W + RECIP_W;

	lpsr_cfg_t cfg_q;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, buffer_valid_q;

	logic [IDX_W-1:0]   idx_s1, idx_s2;
	logic [VALUE_W-1:0] val_s1, val_s2, val_s3;
	logic [PROD_W-1:0]  prod_s2;
	logic [ROW_W-1:0]   row_d, row_s3;
	logic [COL_W-1:0]   col_d, col_s3;
	logic [IDX_W-1:0]   row_span;

	logic [ADDR_W-1:0]     map_addr;
	logic [BUF_ADDR_W-1:0] buffer_address_q;
	logic [VALUE_W-1:0]    buffer_value_q;
	logic                  address_overflow_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_layout <= PANEL_LAYOUT_RESET;
			cfg_q.block_pixels <= BLOCK_PIXELS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PANEL_LAYOUT: cfg_q.panel_layout <= cfg_data[LAYOUT_W-1:0];
				REG_BLOCK_PIXELS: cfg_q.block_pixels <= cfg_data[BLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	// pipe moves whenever the result register is free or being drained
	assign adv         = !buffer_valid_q || buffer_ready;
	assign pixel_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			buffer_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1         <= pixel_valid;
			vld_s2         <= vld_s1;
			vld_s3         <= vld_s2;
			buffer_valid_q <= vld_s3;
		end
	end

	// row from the reciprocal product, column as the remainder
	assign row_d    = prod_s2[RECIP_SHIFT +: ROW_W];
	assign row_span = IDX_W'(row_d) * IDX_W'(SCREEN_WIDTH);
	assign col_d    = COL_W'(idx_s2 - row_span);

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1  <= pixel_index;
			val_s1  <= pixel_value;
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
			prod_s2 <= PROD_W'(idx_s1) * PROD_W'(RECIP);
			row_s3  <= row_d;
			col_s3  <= col_d;
			val_s3  <= val_s2;
			buffer_address_q   <= map_addr[BUF_ADDR_W-1:0];
			buffer_value_q     <= val_s3;
			address_overflow_q <= |map_addr[ADDR_W-1:BUF_ADDR_W];
		end
	end

	lpsr_addr_map #(
		.ROW_W           (ROW_W),
		.COL_W           (COL_W),
		.GROUP_WORDS     (GROUP_WORDS),
		.MODULES_ACROSS  (MODULES_ACROSS),
		.MODULE_WIDTH    (MODULE_WIDTH),
		.SCAN_LINE_WORDS (SCAN_LINE_WORDS)
	) u_addr_map (
		.row  (row_s3),
		.col  (col_s3),
		.cfg  (cfg_q),
		.addr (map_addr)
	);

	assign buffer_valid     = buffer_valid_q;
	assign buffer_address   = buffer_address_q;
	assign buffer_value     = buffer_value_q;
	assign address_overflow = address_overflow_q;

`ifndef NO_ASSERTIONS
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ((COL_W + 1)'(col_s3) < (COL_W + 1)'(SCREEN_WIDTH)))
		else $error("column split out of range");

	a_pixel_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_ready) |=> vld_s1)
		else $error("accepted pixel beat lost at input stage");

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && adv) |=> buffer_valid)
		else $error("last stage advanced without producing a result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(idx_s1)))
		else $error("input stage changed while pipe stalled");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for led_panel_scan_remap_unit: drives pixel beats, predicts scan addresses
// depends on lpsr_pkg and the led_panel_scan_remap_unit rtl
module tb_top;
	import lpsr_pkg::*;

	localparam int SCREEN_W    = 128;
	localparam int GROUP_W     = 16;
	localparam int MOD_ACROSS  = 4;
	localparam int MOD_W       = 32;
	localparam int LINE_W      = 256;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 140;
	localparam int LIMIT_CYCLES = 300000;

	// index outside the register list, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd15;

	typedef struct packed {
		logic [BUF_ADDR_W-1:0] address;
		logic [VALUE_W-1:0]    value;
		logic                  overflow;
	} buf_write_t;

	typedef struct packed {
		logic [LAYOUT_W-1:0]   layout;
		logic [BLOCK_W-1:0]    blk;
		logic [IDX_W-1:0]      index;
		logic [VALUE_W-1:0]    value;
		logic                  typed;
		logic [BUF_ADDR_W-1:0] t_addr;
		logic                  t_ovf;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pixel_valid;
	logic                  pixel_ready;
	logic [IDX_W-1:0]      pixel_index;
	logic [VALUE_W-1:0]    pixel_value;
	logic                  buffer_valid;
	logic                  buffer_ready = 1'b0;
	logic [BUF_ADDR_W-1:0] buffer_address;
	logic [VALUE_W-1:0]    buffer_value;
	logic                  address_overflow;

	buf_write_t pending_writes[$];
	stim_row_t  dir_rows[$];
	int         mismatches = 0;
	int         sink_hold = 0;
	bit         sink_stalls = 1'b1;
	bit         send_gaps = 1'b1;
	logic [LAYOUT_W-1:0] cur_layout = PANEL_LAYOUT_RESET;
	logic [BLOCK_W-1:0]  cur_block = BLOCK_PIXELS_RESET;

	led_panel_scan_remap_unit #(
		.SCREEN_WIDTH(SCREEN_W),
		.GROUP_WORDS(GROUP_W),
		.MODULES_ACROSS(MOD_ACROSS),
		.MODULE_WIDTH(MOD_W),
		.SCAN_LINE_WORDS(LINE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel_index(pixel_index),
		.pixel_value(pixel_value),
		.buffer_valid(buffer_valid),
		.buffer_ready(buffer_ready),
		.buffer_address(buffer_address),
		.buffer_value(buffer_value),
		.address_overflow(address_overflow)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// full-width scan buffer address for one raster pixel
	function automatic longint unsigned scan_address(input logic [LAYOUT_W-1:0] layout,
		input logic [BLOCK_W-1:0] blk, input logic [IDX_W-1:0] idx);
		longint unsigned r, c, g, q, bp, a;
		r = idx / SCREEN_W;
		c = idx % SCREEN_W;
		bp = blk;
		case (layout)
		LAYOUT_P15: begin
			g = c / 4 + (r / 4) * (MOD_ACROSS * 4);
			q = c % 4;
			// first two rows of a group run right to left
			case (r % 4)
			0: a = 2 * (3 - q);
			1: a = 2 * (3 - q) + 1;
			2: a = 2 * q + 9;
			default: a = 2 * q + 8;
			endcase
			a += g * GROUP_W;
		end
		LAYOUT_P5: begin
			g = (r / 16) * 8 + r % 8;
			a = g * GROUP_W + c * 2 + (((r / 8) % 2 == 1) ? 0 : 1);
		end
		LAYOUT_P6: begin
			g = (r / 16) * 8 + r % 8;
			q = c / MOD_W;
			a = c + g * GROUP_W + ((r % 16 >= 8) ? q : q + 1) * MOD_W;
		end
		LAYOUT_P10: begin
			g = (r % 4 + (r / 8) * 4) * (LINE_W / GROUP_W) + c / 8;
			a = g * GROUP_W + ((r % 8 >= 4) ? 15 - c % 8 : c % 8);
		end
		LAYOUT_P5V: begin
			g = (c / 16 + 1) * 8 - 1 - c % 8;
			a = g * LINE_W + r * 2 + (c / 8) % 2;
		end
		default: begin
			// unused codes fall here too
			g = (c / 32) * bp + (((r / 8) % 2) * bp) / 2 + (r % 4) * 4 + (r / 16) * 16
				+ (c % 32) / 8;
			a = g * GROUP_W + c % 8 + ((r % 8 >= 4) ? 8 : 0);
		end
		endcase
		return a;
	endfunction

	function automatic buf_write_t expected_write(input logic [IDX_W-1:0] idx,
		input logic [VALUE_W-1:0] val);
		buf_write_t w;
		longint unsigned a;
		a = scan_address(cur_layout, cur_block, idx);
		w.address = a[BUF_ADDR_W-1:0];
		w.value = val;
		w.overflow = (a > 64'hFFFF);
		return w;
	endfunction

	function automatic void add_row(input logic [LAYOUT_W-1:0] layout,
		input logic [BLOCK_W-1:0] blk, input logic [IDX_W-1:0] idx,
		input logic [VALUE_W-1:0] val, input logic typed,
		input logic [BUF_ADDR_W-1:0] t_addr, input logic t_ovf);
		stim_row_t row;
		row.layout = layout;
		row.blk = blk;
		row.index = idx;
		row.value = val;
		row.typed = typed;
		row.t_addr = t_addr;
		row.t_ovf = t_ovf;
		dir_rows.push_back(row);
	endfunction

	// entered at a falling edge, returns at the falling edge after the beat
	task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] val,
		input buf_write_t w);
		while (send_gaps && $urandom_range(99) < 34) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_index <= idx;
		pixel_value <= val;
		pending_writes.push_back(w);
		do @(posedge clk); while (!pixel_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [LAYOUT_W-1:0] layout,
		input logic [BLOCK_W-1:0] blk, input bit stray);
		write_reg(REG_PANEL_LAYOUT, CFG_DATA_W'(layout));
		write_reg(REG_BLOCK_PIXELS, blk);
		if (stray)
			write_reg(REG_NONE, CFG_DATA_W'($urandom_range(65535)));
		cfg_valid <= 1'b0;
		cur_layout = layout;
		cur_block = blk;
	endtask

	task automatic wait_empty();
		while (pending_writes.size() != 0)
			@(negedge clk);
	endtask

	// result side: random stalls, or a counted hold-off when asked
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			buffer_ready <= 1'b0;
			sink_hold--;
		end else begin
			buffer_ready <= !sink_stalls || ($urandom_range(99) >= 34);
		end
	end

	always @(posedge clk) begin
		buf_write_t e;
		if (arst_n && buffer_valid && buffer_ready) begin
			if (pending_writes.size() == 0) begin
				$error("buffer beat with nothing expected: address %h", buffer_address);
				mismatches++;
			end else begin
				e = pending_writes.pop_front();
				if (buffer_address !== e.address) begin
					$error("buffer_address expected %h actual %h", e.address, buffer_address);
					mismatches++;
				end
				if (buffer_value !== e.value) begin
					$error("buffer_value expected %h actual %h", e.value, buffer_value);
					mismatches++;
				end
				if (address_overflow !== e.overflow) begin
					$error("address_overflow expected %b actual %b", e.overflow,
						address_overflow);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		buf_write_t w;
		stim_row_t row;
		logic [IDX_W-1:0] idx;
		logic [LAYOUT_W-1:0] lay;
		logic [BLOCK_W-1:0] blk;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel_index = '0;
		pixel_value = '0;

		// first rows run on the reset layout with no register write
		add_row(LAYOUT_P15, 16'd64, 12'd0, 8'h00, 1'b1, 16'd6, 1'b0);
		add_row(LAYOUT_P15, 16'd64, 12'd4095, 8'hFF, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P15, 16'd64, 12'h555, 8'hAA, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P15, 16'd64, 12'hAAA, 8'h55, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P5, 16'd64, 12'd0, 8'h01, 1'b1, 16'd1, 1'b0);
		add_row(LAYOUT_P5, 16'd64, 12'd1032, 8'h80, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P5, 16'd64, 12'd4095, 8'hFE, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P6, 16'd64, 12'd0, 8'h10, 1'b1, 16'd32, 1'b0);
		add_row(LAYOUT_P6, 16'd64, 12'd1055, 8'h20, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P6, 16'd64, 12'd4095, 8'h40, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P10, 16'd64, 12'd0, 8'h02, 1'b1, 16'd0, 1'b0);
		add_row(LAYOUT_P10, 16'd64, 12'd608, 8'h04, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P10, 16'd64, 12'd4095, 8'h08, 1'b0, '0, 1'b0);
		add_row(LAYOUT_P5V, 16'd64, 12'd0, 8'h7F, 1'b1, 16'd1792, 1'b0);
		add_row(LAYOUT_P5V, 16'd64, 12'd4095, 8'hF0, 1'b1, 16'd14399, 1'b0);
		add_row(LAYOUT_DEFAULT, 16'd64, 12'd0, 8'h0F, 1'b1, 16'd0, 1'b0);
		add_row(LAYOUT_DEFAULT, 16'd64, 12'd4095, 8'h3C, 1'b0, '0, 1'b0);
		// largest stride pushes the address past 16 bits
		add_row(LAYOUT_DEFAULT, 16'hFFFF, 12'd4095, 8'hC3, 1'b1, 16'h01BF, 1'b1);
		add_row(LAYOUT_DEFAULT, 16'h0000, 12'd4095, 8'h99, 1'b0, '0, 1'b0);
		add_row(LAYOUT_DEFAULT, 16'h0001, 12'd1100, 8'h66, 1'b0, '0, 1'b0);
		add_row(3'd6, 16'd64, 12'd2222, 8'h11, 1'b0, '0, 1'b0);
		add_row(3'd7, 16'hFFFF, 12'd3000, 8'hEE, 1'b0, '0, 1'b0);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.layout != cur_layout || row.blk != cur_block) begin
				pixel_valid <= 1'b0;
				wait_empty();
				set_config(row.layout, row.blk, 1'b0);
			end
			if (row.typed) begin
				w.address = row.t_addr;
				w.value = row.value;
				w.overflow = row.t_ovf;
			end else begin
				w = expected_write(row.index, row.value);
			end
			send_pixel(row.index, row.value, w);
		end

		for (int k = 0; k < PHASES; k++) begin
			pixel_valid <= 1'b0;
			wait_empty();
			lay = (k < 8) ? k[LAYOUT_W-1:0] : LAYOUT_W'($urandom_range(7));
			case ($urandom_range(4))
			0: blk = '0;
			1: blk = '1;
			2: blk = 16'd1;
			3: blk = BLOCK_PIXELS_RESET;
			default: blk = BLOCK_W'($urandom_range(65535));
			endcase
			if (k == 5)
				blk = '1;
			// one phase with no idling on either side, one with a long result hold-off
			send_gaps = (k != 9 && k != 10);
			sink_stalls = (k != 9);
			set_config(lay, blk, k == 3);
			if (k == 10)
				sink_hold = 120;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(7))
				0: idx = $urandom_range(1) ? '0 : '1;
				1, 2: idx = IDX_W'($urandom_range(31) * SCREEN_W + $urandom_range(3) * 32
					+ ($urandom_range(1) ? 0 : 31));
				default: idx = IDX_W'($urandom_range(4095));
				endcase
				w = expected_write(idx, VALUE_W'($urandom_range(255)));
				send_pixel(idx, w.value, w);
			end
		end
		pixel_valid <= 1'b0;

		wait_empty();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/lpsr_pkg.sv
rtl/core/lpsr_addr_map.sv
rtl/core/led_panel_scan_remap_unit.sv
verif/tb_top.sv
